// File: hw/rtl/lwst_pkg.sv
// ----------------------------------------------------------------------------
// lwst_pkg: shared types and constants for the line whitespace trim filter
// Byte codes, payload structs of both channels, and the cell control bundle.
// ----------------------------------------------------------------------------
package lwst_pkg;

  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_VT    = 8'h0B;
  localparam logic [7:0] CHAR_FF    = 8'h0C;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } lws_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       overflow_seen;
  } lws_out_t;

  // Control shared by every cell of the pending chain
  typedef struct packed {
    logic       push;
    logic       shift;
    logic [7:0] wdata;
  } lws_cell_ctrl_t;

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_VT) || (b == CHAR_FF);
  endfunction

  function automatic logic is_eol(input logic [7:0] b);
    return (b == CHAR_CR) || (b == CHAR_LF);
  endfunction

endpackage

// File: hw/rtl/lwst_cell.sv
// ----------------------------------------------------------------------------
// lwst_cell: one slot of the pending whitespace chain
// Loads a byte when selected for a push, takes its upper neighbor's byte on a
// shift, and otherwise holds.
// ----------------------------------------------------------------------------
module lwst_cell (
  input  logic                     clk,
  input  lwst_pkg::lws_cell_ctrl_t ctrl,
  input  logic                     sel,
  input  logic [7:0]               shift_in,
  output logic [7:0]               data
);

  logic [7:0] data_r;
  logic [7:0] data_nxt;

  always_comb begin
    if (ctrl.push && sel) begin
      data_nxt = ctrl.wdata;
    end else if (ctrl.shift) begin
      data_nxt = shift_in;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// File: hw/rtl/line_whitespace_trim_filter.sv
// ----------------------------------------------------------------------------
// line_whitespace_trim_filter: per-line whitespace trimmer
// Holds whitespace runs in a chain of byte cells, releases them ahead of the
// next visible byte, drops them at CR/LF and at end of text.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in_     | input     | in_valid / in_ready   | in_item  (lws_in_t)
//  out_    | output    | out_valid / out_ready | out_item (lws_out_t)
//  cfg_    | input     | cfg_valid / cfg_ready | cfg_strip_leading
//
//  A visible or CR/LF byte with nothing held is accepted and answered directly.
//  A visible byte after N held bytes releases N + 1 output items: the chain
//  shifts one cell per cycle toward the output register, then the byte goes.
//  No input is taken while the chain drains; out_ready low stalls the drain.
//  rst_n (synchronous) empties the chain and sets strip_leading to 1.
// ----------------------------------------------------------------------------
module line_whitespace_trim_filter #(
  parameter int PENDING_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lwst_pkg::lws_in_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output lwst_pkg::lws_out_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_strip_leading
);

  localparam int CNT_W = $clog2(PENDING_DEPTH + 1);

  typedef enum logic {
    S_RUN,
    S_FLUSH
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               als_r, als_nxt;
  logic               ovf_r, ovf_nxt;
  logic               strip_r;
  logic [7:0]         held_r, held_nxt;
  logic               held_eot_r, held_eot_nxt;
  logic               out_valid_r, out_valid_nxt;
  lwst_pkg::lws_out_t out_item_r, out_item_nxt;

  lwst_pkg::lws_cell_ctrl_t ctrl;
  logic [7:0]               cell_q [PENDING_DEPTH];

  logic out_free;
  logic in_acc;
  logic go_flush;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_RUN) && out_free;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign go_flush = in_acc && !lwst_pkg::is_eol(in_item.text_byte)
                    && !lwst_pkg::is_blank(in_item.text_byte) && (count_r != '0);

  for (genvar i = 0; i < PENDING_DEPTH; i++) begin : g_cell
    logic [7:0] up;
    if (i == PENDING_DEPTH - 1) begin : g_top
      assign up = cell_q[i];
    end else begin : g_mid
      assign up = cell_q[i+1];
    end
    lwst_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .sel      (count_r == CNT_W'(i)),
      .shift_in (up),
      .data     (cell_q[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    als_nxt       = als_r;
    ovf_nxt       = ovf_r;
    held_nxt      = held_r;
    held_eot_nxt  = held_eot_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;
    ctrl.push     = 1'b0;
    ctrl.shift    = 1'b0;
    ctrl.wdata    = in_item.text_byte;

    case (state_r)
      S_RUN: begin
        if (in_acc) begin
          if (lwst_pkg::is_eol(in_item.text_byte)) begin
            count_nxt     = '0;
            als_nxt       = 1'b1;
            out_valid_nxt = 1'b1;
            out_item_nxt  = '{out_byte: in_item.text_byte, last_of_run: 1'b1,
                              overflow_seen: ovf_r};
          end else if (lwst_pkg::is_blank(in_item.text_byte)) begin
            // leading blanks in strip mode vanish without touching the queue
            if (!(strip_r && als_r)) begin
              if (count_r < CNT_W'(PENDING_DEPTH)) begin
                ctrl.push = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
          end else begin
            als_nxt = 1'b0;
            if (count_r == '0) begin
              out_valid_nxt = 1'b1;
              out_item_nxt  = '{out_byte: in_item.text_byte, last_of_run: 1'b1,
                                overflow_seen: ovf_r};
            end else begin
              held_nxt     = in_item.text_byte;
              held_eot_nxt = in_item.end_of_text;
              state_nxt    = S_FLUSH;
            end
          end
          if (in_item.end_of_text && !go_flush) begin
            count_nxt = '0;
            als_nxt   = 1'b1;
            ovf_nxt   = 1'b0;
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (count_r != '0) begin
            out_item_nxt = '{out_byte: cell_q[0], last_of_run: 1'b0,
                             overflow_seen: ovf_r};
            ctrl.shift   = 1'b1;
            count_nxt    = count_r - CNT_W'(1);
          end else begin
            out_item_nxt = '{out_byte: held_r, last_of_run: 1'b1,
                             overflow_seen: ovf_r};
            state_nxt    = S_RUN;
            if (held_eot_r) begin
              als_nxt = 1'b1;
              ovf_nxt = 1'b0;
            end
          end
        end
      end
      default: begin
        state_nxt = S_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RUN;
      count_r     <= '0;
      als_r       <= 1'b1;
      ovf_r       <= 1'b0;
      strip_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      als_r       <= als_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        strip_r <= cfg_strip_leading;
      end
    end
    held_r     <= held_nxt;
    held_eot_r <= held_eot_nxt;
    out_item_r <= out_item_nxt;
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(PENDING_DEPTH))
    else $error("pending count beyond chain depth");

  a_no_take_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FLUSH) |-> !in_ready)
    else $error("input taken while chain drains");

  a_flush_ends_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FLUSH) && out_free && (count_r == '0)
    |=> (state_r == S_RUN) && out_valid_r && out_item_r.last_of_run)
    else $error("drain did not end with the visible byte");

  a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_item.end_of_text && !go_flush
    |=> (count_r == '0) && als_r && !ovf_r)
    else $error("end of text left stream state behind");
`endif

endmodule
